/* design/sgr_pkg.sv */
// Shared types, codes and constants of the sandpile grid relaxer.
package sgr_pkg;

	localparam int CMD_W   = 2;
	localparam int COL_W   = 6;
	localparam int ROW_W   = 6;
	localparam int AMT_W   = 8;
	localparam int VAL_W   = 8;
	localparam int SWEEP_W = 16;

	localparam int DEF_GRID_WIDTH  = 64;
	localparam int DEF_GRID_HEIGHT = 64;

	localparam logic [VAL_W-1:0] TOPPLE_LEVEL = 8'd4;

	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STAB = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_RD_ISSUE,
		OP_RD_DONE,
		OP_SW_INIT,
		OP_SW_STEP,
		OP_SW_END
	} dp_op_t;

	typedef struct packed {
		logic clear_last;
		logic req_stab;
		logic region_empty;
		logic sweep_last;
		logic moved;
		logic out_free;
	} dp_stat_t;

endpackage

/* design/sgr_req_if.sv */
// Request channel: command and cell address with valid/ready.
interface sgr_req_if import sgr_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [AMT_W-1:0]  amount;

	modport source(output valid, command, col, row, amount, input ready);
	modport sink(input valid, command, col, row, amount, output ready);
endinterface

/* design/sgr_rsp_if.sv */
// Result channel: cell value and sweep count with valid/ready.
interface sgr_rsp_if import sgr_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [VAL_W-1:0]    cell_value;
	logic [SWEEP_W-1:0]  sweep_count;

	modport source(output valid, cell_value, sweep_count, input ready);
	modport sink(input valid, cell_value, sweep_count, output ready);
endinterface

/* design/sandpile_grid_relaxer_core.sv */
// Top level of the sandpile grid relaxer: controller plus datapath.
//
//  channel   dir  handshake      payload
//  request   in   valid/ready    command, col, row, amount
//  result    out  valid/ready    cell_value, sweep_count
//
// After reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells zeroes both grid banks;
// no request is taken until it ends. Add and read load the request, issue the read, then
// register the result. Stabilize repeats sweeps over the box grown by one until none moves,
// then reads the cell: each cell needs five reads through the single read port.
// One request is in flight at a time; a waiting result stalls only the final step.
module sandpile_grid_relaxer_core import sgr_pkg::*; #(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
	input  logic         clk,
	input  logic         arst_n,
	sgr_req_if.sink      request,
	sgr_rsp_if.source    result
);
	dp_op_t   op;
	dp_stat_t stat;

	sgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.stat     (stat),
		.op       (op)
	);

	sgr_dpath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.command     (request.command),
		.col         (request.col),
		.row         (request.row),
		.amount      (request.amount),
		.stat        (stat),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.cell_value  (result.cell_value),
		.sweep_count (result.sweep_count)
	);
endmodule

/* design/sgr_ram.sv */
// Generic single write port, single read port RAM with registered read.
module sgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_data_q;
endmodule

/* design/sgr_ctrl.sv */
// Controller state machine: sequences clear, add, read and sweep operations.
module sgr_ctrl import sgr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_op_t   op
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_RD_WAIT,
		S_SW_INIT,
		S_SW_RUN,
		S_SW_END
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = stat.req_stab ? S_SW_INIT : S_RD;
				end
			end
			S_RD: begin
				op      = OP_RD_ISSUE;
				state_d = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				// hold the read data until the result slot frees up
				if (stat.out_free) begin
					op      = OP_RD_DONE;
					state_d = S_IDLE;
				end
			end
			S_SW_INIT: begin
				op      = OP_SW_INIT;
				state_d = stat.region_empty ? S_SW_END : S_SW_RUN;
			end
			S_SW_RUN: begin
				op = OP_SW_STEP;
				if (stat.sweep_last) state_d = S_SW_END;
			end
			S_SW_END: begin
				op      = OP_SW_END;
				state_d = stat.moved ? S_SW_INIT : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* design/sgr_dpath.sv */
// Datapath: grid banks, bounding box, sweep scan and result register.
module sgr_dpath import sgr_pkg::*; #(
	parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	input  logic [CMD_W-1:0]   command,
	input  logic [COL_W-1:0]   col,
	input  logic [ROW_W-1:0]   row,
	input  logic [AMT_W-1:0]   amount,
	output dp_stat_t           stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VAL_W-1:0]   cell_value,
	output logic [SWEEP_W-1:0] sweep_count
);
	localparam int CW    = $clog2(GRID_WIDTH);
	localparam int RW    = $clog2(GRID_HEIGHT);
	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_HEIGHT - 1);
	localparam logic [2:0]    PH_LAST  = 3'd5;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
		return AW'(int'(r) * GRID_WIDTH + int'(c));
	endfunction

	logic [CMD_W-1:0]   cmd_q;
	logic [CW-1:0]      pc_q;
	logic [RW-1:0]      pr_q;
	logic [AMT_W-1:0]   amt_q;
	logic               ongrid_q;
	logic [CW-1:0]      bminc_q, bmaxc_q;
	logic [RW-1:0]      bminr_q, bmaxr_q;
	logic [CW-1:0]      rc0_q, rc1_q, sc_q;
	logic [RW-1:0]      rr0_q, rr1_q, sr_q;
	logic [2:0]         ph_q;
	logic [VAL_W-1:0]   cen_q;
	logic [2:0]         cnt_q;
	logic               moved_q;
	logic               bank_q;
	logic [AW-1:0]      clr_q;
	logic [SWEEP_W-1:0] sweeps_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   val_q;
	logic [SWEEP_W-1:0] swc_q;

	// expanded box: every cell a sweep may change
	logic [CW-1:0] ec0, ec1;
	logic [RW-1:0] er0, er1;
	assign ec0 = (bminc_q != '0) ? bminc_q - CW'(1) : '0;
	assign ec1 = (bmaxc_q != COL_LAST) ? bmaxc_q + CW'(1) : COL_LAST;
	assign er0 = (bminr_q != '0) ? bminr_q - RW'(1) : '0;
	assign er1 = (bmaxr_q != ROW_LAST) ? bmaxr_q + RW'(1) : ROW_LAST;

	// box growth around one cell
	logic [CW-1:0] gc, lo_c, hi_c, gminc, gmaxc;
	logic [RW-1:0] gr, lo_r, hi_r, gminr, gmaxr;
	assign gc    = (op == OP_SW_STEP) ? sc_q : pc_q;
	assign gr    = (op == OP_SW_STEP) ? sr_q : pr_q;
	assign lo_c  = (gc != '0) ? gc - CW'(1) : '0;
	assign hi_c  = (gc != COL_LAST) ? gc + CW'(1) : COL_LAST;
	assign lo_r  = (gr != '0) ? gr - RW'(1) : '0;
	assign hi_r  = (gr != ROW_LAST) ? gr + RW'(1) : ROW_LAST;
	assign gminc = (lo_c < bminc_q) ? lo_c : bminc_q;
	assign gmaxc = (hi_c > bmaxc_q) ? hi_c : bmaxc_q;
	assign gminr = (lo_r < bminr_q) ? lo_r : bminr_q;
	assign gmaxr = (hi_r > bmaxr_q) ? hi_r : bmaxr_q;

	logic n_ok, s_ok, w_ok, e_ok;
	assign n_ok = (sr_q != '0);
	assign s_ok = (sr_q != ROW_LAST);
	assign w_ok = (sc_q != '0);
	assign e_ok = (sc_q != COL_LAST);

	logic [AW-1:0] cen_addr, nb_addr, req_addr;
	assign cen_addr = addr_of(sc_q, sr_q);
	assign req_addr = addr_of(pc_q, pr_q);

	// read order per cell: center, north, south, west, east
	always_comb begin
		unique case (ph_q)
			3'd1:    nb_addr = n_ok ? addr_of(sc_q, sr_q - RW'(1)) : cen_addr;
			3'd2:    nb_addr = s_ok ? addr_of(sc_q, sr_q + RW'(1)) : cen_addr;
			3'd3:    nb_addr = w_ok ? addr_of(sc_q - CW'(1), sr_q) : cen_addr;
			3'd4:    nb_addr = e_ok ? addr_of(sc_q + CW'(1), sr_q) : cen_addr;
			default: nb_addr = cen_addr;
		endcase
	end

	logic [VAL_W-1:0] rd0, rd1, rd_data;
	assign rd_data = bank_q ? rd1 : rd0;

	logic nb_ok;
	always_comb begin
		unique case (ph_q)
			3'd2:    nb_ok = n_ok;
			3'd3:    nb_ok = s_ok;
			3'd4:    nb_ok = w_ok;
			3'd5:    nb_ok = e_ok;
			default: nb_ok = 1'b0;
		endcase
	end

	logic             nb_hot, cen_hot;
	logic [2:0]       cnt_sum;
	logic [VAL_W-1:0] cen_cut, new_val, add_sum;
	assign nb_hot  = nb_ok && (rd_data >= TOPPLE_LEVEL);
	assign cen_hot = (cen_q >= TOPPLE_LEVEL);
	assign cnt_sum = cnt_q + 3'(nb_hot);
	assign cen_cut = cen_hot ? cen_q - TOPPLE_LEVEL : cen_q;
	assign new_val = cen_cut + VAL_W'(cnt_sum);
	assign add_sum = rd_data + amt_q;

	logic re, clr_we, add_we, sw_we, we0, we1;
	logic [AW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	assign re     = (op == OP_RD_ISSUE) || ((op == OP_SW_STEP) && (ph_q < PH_LAST));
	assign clr_we = (op == OP_CLEAR);
	assign add_we = (op == OP_RD_DONE) && (cmd_q == CMD_ADD) && ongrid_q;
	assign sw_we  = (op == OP_SW_STEP) && (ph_q == PH_LAST);
	// sweeps write the spare bank, adds the live one
	assign we0    = clr_we || (add_we && !bank_q) || (sw_we && bank_q);
	assign we1    = clr_we || (add_we && bank_q) || (sw_we && !bank_q);
	assign waddr  = clr_we ? clr_q : (add_we ? req_addr : cen_addr);
	assign wdata  = clr_we ? '0 : (add_we ? add_sum : new_val);

	sgr_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr ((op == OP_RD_ISSUE) ? req_addr : nb_addr),
		.rdata (rd0)
	);

	sgr_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr ((op == OP_RD_ISSUE) ? req_addr : nb_addr),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bminc_q     <= COL_LAST;
			bmaxc_q     <= '0;
			bminr_q     <= ROW_LAST;
			bmaxr_q     <= '0;
			bank_q      <= 1'b0;
			clr_q       <= '0;
			moved_q     <= 1'b0;
			sweeps_q    <= '0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_CLEAR: clr_q <= clr_q + AW'(1);
				OP_LOAD:  sweeps_q <= '0;
				OP_RD_DONE: begin
					if (add_we) begin
						bminc_q <= gminc;
						bmaxc_q <= gmaxc;
						bminr_q <= gminr;
						bmaxr_q <= gmaxr;
					end
				end
				OP_SW_INIT: begin
					moved_q <= 1'b0;
					ph_q    <= '0;
				end
				OP_SW_STEP: begin
					if (ph_q == PH_LAST) begin
						ph_q <= '0;
						if (cen_hot) begin
							moved_q <= 1'b1;
							bminc_q <= gminc;
							bmaxc_q <= gmaxc;
							bminr_q <= gminr;
							bmaxr_q <= gmaxr;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				OP_SW_END: begin
					bank_q <= ~bank_q;
					if (sweeps_q != '1) sweeps_q <= sweeps_q + SWEEP_W'(1);
				end
				default: ;
			endcase
			if (op == OP_RD_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				cmd_q    <= command;
				pc_q     <= CW'(col);
				pr_q     <= RW'(row);
				amt_q    <= amount;
				ongrid_q <= (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
			end
			OP_RD_DONE: begin
				swc_q <= sweeps_q;
				if (!ongrid_q) begin
					val_q <= '0;
				end else if (cmd_q == CMD_ADD) begin
					val_q <= add_sum;
				end else begin
					val_q <= rd_data;
				end
			end
			OP_SW_INIT: begin
				rc0_q <= ec0;
				rc1_q <= ec1;
				rr0_q <= er0;
				rr1_q <= er1;
				sc_q  <= ec0;
				sr_q  <= er0;
			end
			OP_SW_STEP: begin
				if (ph_q == 3'd1) begin
					cen_q <= rd_data;
					cnt_q <= '0;
				end else if (ph_q != '0 && ph_q != PH_LAST) begin
					cnt_q <= cnt_sum;
				end
				if (ph_q == PH_LAST) begin
					// advance raster scan over the expanded box
					if (sc_q == rc1_q) begin
						sc_q <= rc0_q;
						sr_q <= sr_q + RW'(1);
					end else begin
						sc_q <= sc_q + CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.clear_last   = (clr_q == AW'(CELLS - 1));
	assign stat.req_stab     = (command == CMD_STAB);
	assign stat.region_empty = (ec0 > ec1) || (er0 > er1);
	assign stat.sweep_last   = (ph_q == PH_LAST) && (sc_q == rc1_q) && (sr_q == rr1_q);
	assign stat.moved        = moved_q;
	assign stat.out_free     = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign cell_value  = val_q;
	assign sweep_count = swc_q;

`ifndef SYNTH
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= PH_LAST)
		else $error("cell phase out of range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_RD_DONE) |=> out_valid_q)
		else $error("result not presented after completion");

	a_scan_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SW_STEP) |-> (sc_q >= rc0_q) && (sc_q <= rc1_q) &&
			(sr_q >= rr0_q) && (sr_q <= rr1_q))
		else $error("sweep scan left the region");
`endif
endmodule
